>>> src/wnea_pkg.sv
`default_nettype none
package wnea_pkg;

   localparam int FracBitsDefault = 16;
   localparam int AccWidthDefault = 64;
   localparam int CountWidthDefault = 32;

   localparam int NumJac = 6;
   localparam int NumInfo = 21;
   localparam int NumGrad = 6;
   localparam int NumTerms = 28;
   localparam int NumEntries = 29;
   localparam int QueueDepth = 2;

   // Input item as it crosses the request port
   typedef struct packed {
      logic signed [31:0] jac_0;
      logic signed [31:0] jac_1;
      logic signed [31:0] jac_2;
      logic signed [31:0] jac_3;
      logic signed [31:0] jac_4;
      logic signed [31:0] jac_5;
      logic signed [31:0] residual_distance;
      logic [16:0]        sample_weight;
      logic               last_item;
   } req_item_type;

   // One result entry
   typedef struct packed {
      logic [4:0]         entry_index;
      logic signed [63:0] entry_value;
      logic               last_entry;
      logic               overflow_seen;
   } rsp_item_type;

   // Operand vector queued between front and back
   typedef struct packed {
      logic signed [6:0][31:0] opnd;
      logic [16:0]             weight;
      logic                    last;
   } work_item_type;

   // Queue status: full is seen by the front, empty by the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Operand pair of term k (0..20 info, 21..26 gradient, 27 cost);
   // operand 6 is the residual
   function automatic logic [2:0] term_a(input logic [4:0] k);
      logic [2:0] a;
      a = 3'd6;
      if (k <= 5'd5) a = 3'd0;
      else if (k <= 5'd10) a = 3'd1;
      else if (k <= 5'd14) a = 3'd2;
      else if (k <= 5'd17) a = 3'd3;
      else if (k <= 5'd19) a = 3'd4;
      else if (k == 5'd20) a = 3'd5;
      else if (k <= 5'd26) a = 3'(k - 5'd21);
      return a;
   endfunction

   function automatic logic [2:0] term_b(input logic [4:0] k);
      logic [2:0] b;
      b = 3'd6;
      if (k <= 5'd5) b = 3'(k);
      else if (k <= 5'd10) b = 3'(k - 5'd5);
      else if (k <= 5'd14) b = 3'(k - 5'd9);
      else if (k <= 5'd17) b = 3'(k - 5'd12);
      else if (k <= 5'd19) b = 3'(k - 5'd14);
      else if (k == 5'd20) b = 3'd5;
      return b;
   endfunction

endpackage
`default_nettype wire

>>> src/wnea_front.sv
`default_nettype none
module wnea_front (
   input  wire logic                       start,
   input  wire wnea_pkg::req_item_type     req_item,
   input  wire logic                       q_full,
   output logic                            busy,
   output logic                            push,
   output wnea_pkg::work_item_type         push_item
);

   // Hold off the requester while the queue is full
   assign busy = q_full;
   assign push = start && !busy;

   // Pack the item into an operand vector
   always_comb begin
      push_item.opnd[0] = req_item.jac_0;
      push_item.opnd[1] = req_item.jac_1;
      push_item.opnd[2] = req_item.jac_2;
      push_item.opnd[3] = req_item.jac_3;
      push_item.opnd[4] = req_item.jac_4;
      push_item.opnd[5] = req_item.jac_5;
      push_item.opnd[6] = req_item.residual_distance;
      push_item.weight  = req_item.sample_weight;
      push_item.last    = req_item.last_item;
   end

endmodule
`default_nettype wire

>>> src/wnea_queue.sv
`default_nettype none
module wnea_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire wnea_pkg::work_item_type    push_item,
   input  wire logic                       pop,
   output wnea_pkg::work_item_type         head_item,
   output wnea_pkg::queue_status_type      q_status
);

   localparam int Depth = wnea_pkg::QueueDepth;
   localparam int PtrW = $clog2(Depth);

   wnea_pkg::work_item_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]   count_ff, count_in;

   assign q_status.full  = count_ff == (PtrW+1)'(Depth);
   assign q_status.empty = count_ff == '0;
   assign head_item = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth-1)) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_in + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth-1)) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset) q_status.full |-> !push)
      else $error("queue overrun");
   assert property (@(posedge clock) disable iff (reset) q_status.empty |-> !pop)
      else $error("queue underrun");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count slip");

endmodule
`default_nettype wire

>>> src/wnea_back.sv
`default_nettype none
module wnea_back #(
   parameter int FRAC_BITS   = wnea_pkg::FracBitsDefault,
   parameter int ACC_WIDTH   = wnea_pkg::AccWidthDefault,
   parameter int COUNT_WIDTH = wnea_pkg::CountWidthDefault
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire wnea_pkg::work_item_type    head_item,
   input  wire logic                       q_empty,
   output logic                            pop,
   output logic                            rsp_valid,
   output wnea_pkg::rsp_item_type          rsp_item
);

   localparam int TermShift = 2 * FRAC_BITS - 16;
   localparam int NTerm = wnea_pkg::NumTerms;
   localparam int NEnt = wnea_pkg::NumEntries;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StMul  = 2'd1;
   localparam logic [1:0] StAcc  = 2'd2;
   localparam logic [1:0] StEmit = 2'd3;

   localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   logic [1:0] state_ff, state_in;
   logic [4:0] k_ff, k_in;
   logic signed [ACC_WIDTH-1:0] acc_ff [NTerm];
   logic [COUNT_WIDTH-1:0] count_ff;
   logic sat_ff;
   logic signed [63:0] prod_ff;     // a*b
   logic [16:0] w_ff;
   logic signed [81:0] term_ff;     // a*b*w exact
   logic acc_phase_ff;
   logic rsp_valid_ff;
   wnea_pkg::rsp_item_type rsp_item_ff;

   // Operand select and first product
   logic signed [31:0] opa, opb;
   assign opa = head_item.opnd[wnea_pkg::term_a(k_ff)];
   assign opb = head_item.opnd[wnea_pkg::term_b(k_ff)];

   // Rescale and saturate the term
   logic signed [81:0] shifted;
   logic signed [ACC_WIDTH-1:0] term_sat;
   logic term_ovf;
   assign shifted = term_ff >>> TermShift;
   always_comb begin
      term_ovf = 1'b0;
      term_sat = shifted[ACC_WIDTH-1:0];
      if (shifted > 82'(signed'(AccMax))) begin
         term_sat = AccMax;
         term_ovf = 1'b1;
      end else if (shifted < 82'(signed'(AccMin))) begin
         term_sat = AccMin;
         term_ovf = 1'b1;
      end
   end

   // Saturating accumulate
   logic signed [ACC_WIDTH:0] sum_wide;
   logic signed [ACC_WIDTH-1:0] sum_sat;
   logic sum_ovf;
   assign sum_wide = {acc_ff[k_ff][ACC_WIDTH-1], acc_ff[k_ff]} +
                     {term_sat[ACC_WIDTH-1], term_sat};
   always_comb begin
      sum_ovf = sum_wide[ACC_WIDTH] != sum_wide[ACC_WIDTH-1];
      sum_sat = sum_wide[ACC_WIDTH-1:0];
      if (sum_ovf) sum_sat = sum_wide[ACC_WIDTH] ? AccMin : AccMax;
   end

   logic last_term;
   assign last_term = k_ff == 5'(NTerm - 1);

   // Sequencer: per term a multiply step, a weight step and an add step
   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      pop = 1'b0;
      unique case (state_ff)
         StIdle: if (!q_empty) begin
            state_in = StMul;
            k_in = '0;
         end
         StMul: state_in = StAcc;
         StAcc: if (acc_phase_ff) begin
            if (last_term) begin
               k_in = '0;
               if (head_item.last) state_in = StEmit;
               else begin
                  state_in = StIdle;
                  pop = 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
               state_in = StMul;
            end
         end
         StEmit: if (k_ff == 5'(NEnt - 1)) begin
            state_in = StIdle;
            pop = 1'b1;
            k_in = '0;
         end else begin
            k_in = k_ff + 1'b1;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         k_ff <= '0;
         acc_phase_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         acc_phase_ff <= (state_ff == StAcc) ? !acc_phase_ff : 1'b0;
         rsp_valid_ff <= state_ff == StEmit;
      end
   end

   // Datapath pipeline: product, then weighted term
   always_ff @(posedge clock) begin
      prod_ff <= opa * opb;
      w_ff <= head_item.weight;
      term_ff <= prod_ff * signed'({1'b0, w_ff});
   end

   // Accumulators, count and saturation flag
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTerm; i++) acc_ff[i] <= '0;
         count_ff <= '0;
         sat_ff <= 1'b0;
      end else if (state_ff == StAcc && acc_phase_ff) begin
         acc_ff[k_ff] <= sum_sat;
         if (term_ovf || sum_ovf) sat_ff <= 1'b1;
         if (last_term) begin
            if (&count_ff) sat_ff <= 1'b1;
            else count_ff <= count_ff + 1'b1;
         end
      end else if (state_ff == StEmit && k_ff == 5'(NEnt - 1)) begin
         for (int i = 0; i < NTerm; i++) acc_ff[i] <= '0;
         count_ff <= '0;
         sat_ff <= 1'b0;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      rsp_item_ff.entry_index <= k_ff;
      rsp_item_ff.last_entry <= k_ff == 5'(NEnt - 1);
      rsp_item_ff.overflow_seen <= sat_ff;
      if (k_ff == 5'(NEnt - 1))
         rsp_item_ff.entry_value <= 64'(count_ff);
      else
         rsp_item_ff.entry_value <= 64'(acc_ff[k_ff]);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last_entry |-> rsp_item.entry_index == 5'(NEnt - 1))
      else $error("last entry misplaced");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == StAcc || state_ff == StEmit))
      else $error("pop outside work");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == StEmit |=> rsp_valid)
      else $error("emit lost");

endmodule
`default_nettype wire

>>> src/weighted_normal_equation_accumulator_top.sv
`default_nettype none
// Weighted normal-equation accumulator, six degrees of freedom.
// Request: drive req_item and raise start; the item is a transfer at a
// clock edge with start high and busy low. busy rises while the two-entry
// queue between the front and the back is full.
// The back works each item as 28 terms; each term takes a multiply of
// Jacobian or residual operands, a weight multiply, then the saturating
// add. The back takes the next item from the queue only once it is done
// with the last one, so items are worked one at a time.
// An item with last_item set is followed by 29 results, one per cycle on
// rsp_valid: entries 0..20 info matrix, 21..26 gradient, 27 cost, 28 count;
// last_entry marks entry 28. The receiver cannot stall; each result is
// shown for exactly one cycle. The sums clear after the run.
// Reset (synchronous, active high) clears all sums, the count, the
// overflow flag and the queue.
module weighted_normal_equation_accumulator_top #(
   parameter int FRAC_BITS   = wnea_pkg::FracBitsDefault,
   parameter int ACC_WIDTH   = wnea_pkg::AccWidthDefault,
   parameter int COUNT_WIDTH = wnea_pkg::CountWidthDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire wnea_pkg::req_item_type req_item,
   output logic                        rsp_valid,
   output wnea_pkg::rsp_item_type      rsp_item
);

   logic push, pop;
   wnea_pkg::work_item_type push_item, head_item;
   wnea_pkg::queue_status_type q_status;

   wnea_front u_front (
      .start(start), .req_item(req_item), .q_full(q_status.full),
      .busy(busy), .push(push), .push_item(push_item)
   );

   wnea_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .head_item(head_item), .q_status(q_status)
   );

   wnea_back #(
      .FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)
   ) u_back (
      .clock(clock), .reset(reset), .head_item(head_item),
      .q_empty(q_status.empty), .pop(pop), .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

endmodule
`default_nettype wire

>>> test/tb_weighted_normal_equation_accumulator_top.sv
`default_nettype none
module tb_weighted_normal_equation_accumulator_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint AccMax = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint AccMin = 64'sh8000_0000_0000_0000;
   localparam longint unsigned CountMax = 64'hFFFF_FFFF;
   localparam int Limit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   wnea_pkg::req_item_type req_item = '0;
   logic rsp_valid;
   wnea_pkg::rsp_item_type rsp_item;

   weighted_normal_equation_accumulator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   longint info_acc [wnea_pkg::NumInfo];
   longint grad_acc [wnea_pkg::NumGrad];
   longint cost_acc;
   longint unsigned pair_count;
   bit sat_seen;

   wnea_pkg::req_item_type pending_items[$];
   wnea_pkg::rsp_item_type expected_entries[$];
   int errors = 0;
   int idle_pct = 0;
   bit hold_send = 1'b0;
   int cycles = 0;
   int entries_seen = 0;
   int sets_sent = 0;

   task automatic report_mismatch(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   function automatic void add_pending(input wnea_pkg::req_item_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic void clear_sums();
      foreach (info_acc[i]) info_acc[i] = 0;
      foreach (grad_acc[i]) grad_acc[i] = 0;
      cost_acc = 0;
      pair_count = 0;
      sat_seen = 1'b0;
   endfunction

   // a*b*w floored to Q32.32, saturated to 64 bits
   function automatic longint scaled_term(input longint a, input longint b,
                                          input longint w);
      logic signed [113:0] p;
      p = 114'(a) * 114'(b) * 114'(w);
      p = p >>> 16;
      if (p > 114'(AccMax)) begin
         sat_seen = 1'b1;
         return AccMax;
      end
      if (p < 114'(AccMin)) begin
         sat_seen = 1'b1;
         return AccMin;
      end
      return longint'(p);
   endfunction

   function automatic longint sat_sum(input longint acc, input longint t);
      logic signed [64:0] s;
      s = 65'(acc) + 65'(t);
      if (s > 65'(AccMax)) begin
         sat_seen = 1'b1;
         return AccMax;
      end
      if (s < 65'(AccMin)) begin
         sat_seen = 1'b1;
         return AccMin;
      end
      return longint'(s);
   endfunction

   // fold one residual into the sums; emit the set on last_item
   function automatic void accumulate(input wnea_pkg::req_item_type it);
      longint opnd [7];
      longint w;
      int k;
      wnea_pkg::rsp_item_type e;
      opnd[0] = it.jac_0; opnd[1] = it.jac_1; opnd[2] = it.jac_2;
      opnd[3] = it.jac_3; opnd[4] = it.jac_4; opnd[5] = it.jac_5;
      opnd[6] = it.residual_distance;
      w = longint'(it.sample_weight);
      k = 0;
      for (int i = 0; i < 6; i++)
         for (int j = i; j < 6; j++) begin
            info_acc[k] = sat_sum(info_acc[k], scaled_term(opnd[i], opnd[j], w));
            k++;
         end
      for (int i = 0; i < 6; i++)
         grad_acc[i] = sat_sum(grad_acc[i], scaled_term(opnd[i], opnd[6], w));
      cost_acc = sat_sum(cost_acc, scaled_term(opnd[6], opnd[6], w));
      if (pair_count >= CountMax) begin
         pair_count = CountMax;
         sat_seen = 1'b1;
      end else pair_count++;
      if (!it.last_item) return;
      for (int n = 0; n < wnea_pkg::NumEntries; n++) begin
         e.entry_index = 5'(n);
         if (n < wnea_pkg::NumInfo) e.entry_value = info_acc[n];
         else if (n < wnea_pkg::NumInfo + wnea_pkg::NumGrad)
            e.entry_value = grad_acc[n - wnea_pkg::NumInfo];
         else if (n == 27) e.entry_value = cost_acc;
         else e.entry_value = longint'(pair_count);
         e.last_entry = (n == 28);
         e.overflow_seen = sat_seen;
         expected_entries.insert(expected_entries.size(), e);
      end
      clear_sums();
   endfunction

   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
         3: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
         default: return $urandom;
      endcase
   endfunction

   function automatic wnea_pkg::req_item_type rand_item(input bit last);
      wnea_pkg::req_item_type it;
      it.jac_0 = rand_q(); it.jac_1 = rand_q(); it.jac_2 = rand_q();
      it.jac_3 = rand_q(); it.jac_4 = rand_q(); it.jac_5 = rand_q();
      it.residual_distance = rand_q();
      case ($urandom_range(0, 4))
         0: it.sample_weight = 17'd0;
         1: it.sample_weight = 17'd65536;
         2: it.sample_weight = 17'($urandom_range(65537, 131071));
         default: it.sample_weight = 17'($urandom_range(0, 65536));
      endcase
      it.last_item = last;
      return it;
   endfunction

   function automatic wnea_pkg::req_item_type fixed_item(input logic [31:0] j,
      input logic [31:0] r, input logic [16:0] w, input bit last);
      wnea_pkg::req_item_type it;
      it.jac_0 = j; it.jac_1 = j; it.jac_2 = j; it.jac_3 = j;
      it.jac_4 = j; it.jac_5 = j;
      it.residual_distance = r;
      it.sample_weight = w;
      it.last_item = last;
      return it;
   endfunction

   // driver: present the queue head, hold it until the transfer
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            accumulate(req_item);
            void'(pending_items.pop_front());
         end
         if ((start && busy)) begin
            // hold the item
         end else if (pending_items.size() != 0 && !hold_send
                      && ($urandom_range(0, 99) >= idle_pct)) begin
            req_item <= (start && !busy) ?
                        (pending_items.size() > 0 ? pending_items[0] : req_item)
                        : pending_items[0];
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed result against the oldest expected entry
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid) begin
         entries_seen++;
         if (expected_entries.size() == 0) begin
            report_mismatch($sformatf("unexpected entry %0d", rsp_item.entry_index));
         end else begin
            wnea_pkg::rsp_item_type e;
            e = expected_entries.pop_front();
            if (rsp_item.entry_index !== e.entry_index)
               report_mismatch($sformatf("index %0d, want %0d",
                               rsp_item.entry_index, e.entry_index));
            if (rsp_item.entry_value !== e.entry_value)
               report_mismatch($sformatf("entry %0d value %h, want %h",
                               e.entry_index, rsp_item.entry_value, e.entry_value));
            if (rsp_item.last_entry !== e.last_entry)
               report_mismatch($sformatf("entry %0d last_entry %b",
                               e.entry_index, rsp_item.last_entry));
            if (rsp_item.overflow_seen !== e.overflow_seen)
               report_mismatch($sformatf("entry %0d overflow_seen %b, want %b",
                               e.entry_index, rsp_item.overflow_seen, e.overflow_seen));
         end
      end
      if (cycles > Limit) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_items.size() != 0 || start) @(posedge clock);
      while (expected_entries.size() != 0) @(posedge clock);
   endtask

   initial begin
      int set_len;
      int sent;
      clear_sums();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero weight, weight above one, saturation
      add_pending(fixed_item(32'h0001_0000, 32'h0002_0000, 17'd65536, 1'b1));
      add_pending(fixed_item(32'h7FFF_FFFF, 32'h8000_0000, 17'd0, 1'b1));
      add_pending(fixed_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'd131071, 1'b0));
      add_pending(fixed_item(32'h8000_0000, 32'h8000_0000, 17'd131071, 1'b0));
      add_pending(fixed_item(32'h8000_0000, 32'h7FFF_FFFF, 17'd65536, 1'b1));
      add_pending(fixed_item(32'hFFFF_FFFF, 32'h0000_0001, 17'd1, 1'b0));
      add_pending(fixed_item(32'h8000_0000, 32'h8000_0000, 17'd65536, 1'b0));
      add_pending(fixed_item(32'h8000_0000, 32'h8000_0000, 17'd65536, 1'b0));
      add_pending(fixed_item(32'h8000_0000, 32'h8000_0000, 17'd65536, 1'b1));
      add_pending(fixed_item(32'hFFFF_8000, 32'h0000_8000, 17'd65537, 1'b1));
      add_pending(fixed_item(32'h0, 32'h0, 17'd0, 1'b1));

      // pause until every expected entry is back
      wait_drained();

      // random sets of 1..6 residuals, with varied idling
      sent = 0;
      while (sent < 100) begin
         case (sets_sent % 4)
            0: idle_pct = 0;
            1: idle_pct = 56;
            2: idle_pct = 38;
            default: idle_pct = $urandom_range(0, 90);
         endcase
         set_len = $urandom_range(1, 6);
         for (int i = 0; i < set_len; i++)
            add_pending(rand_item(i == set_len - 1));
         sent += set_len;
         sets_sent++;
         if (sets_sent % 5 == 0) begin
            hold_send = 1'b1;
            while (expected_entries.size() != 0 || start) @(posedge clock);
            hold_send = 1'b0;
         end
         while (pending_items.size() > 4) @(posedge clock);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d random sets plus directed extremes, %0d entries checked",
               sets_sent, entries_seen);
      if (errors == 0 && expected_entries.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d entries outstanding", errors,
                  expected_entries.size());
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
